// ===== design/cmf_pkg.sv =====
// Shared types and constants of the checksummed message framer.
// Used by the front, queue, back and top-level modules; depends on nothing.
package cmf_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // Request kinds on the input tuser bit.
    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;

    // Command kinds passed from front to back.
    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_PAYLOAD = 2'd1;
    localparam logic [1:0] CMD_ERROR   = 2'd2;

    // Output steps of a start command.
    localparam logic [2:0] STEP_SYNC1  = 3'd0;
    localparam logic [2:0] STEP_SYNC2  = 3'd1;
    localparam logic [2:0] STEP_CLASS  = 3'd2;
    localparam logic [2:0] STEP_ID     = 3'd3;
    localparam logic [2:0] STEP_LEN_LO = 3'd4;
    localparam logic [2:0] STEP_LEN_HI = 3'd5;
    localparam logic [2:0] STEP_HDR_A  = 3'd6;
    localparam logic [2:0] STEP_HDR_B  = 3'd7;

    // Output steps of a payload command.
    localparam logic [2:0] STEP_PB     = 3'd0;
    localparam logic [2:0] STEP_PB_A   = 3'd1;
    localparam logic [2:0] STEP_PB_B   = 3'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] msg_class;
        logic [7:0] msg_id;
        logic [7:0] len_lo;
        logic [7:0] len_hi;
        logic [7:0] pbyte;
        logic [7:0] sum_a;
        logic [7:0] sum_b;
        logic       closes;  // this command ends the frame with checksum bytes
    } t_cmd;

endpackage

// ===== design/cmf_front.sv =====
// Front end of the framer: accepts request items, tracks the frame state
// and running Fletcher sums, and issues one command per item. Uses cmf_pkg.
module cmf_front
    import cmf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_msg_class,
    input  logic [7:0]  i_msg_id,
    input  logic [15:0] i_payload_length,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic        r_frame_open, n_frame_open;

    logic [7:0] h_a1, h_a2, h_a3, h_a4;
    logic [7:0] h_b2, h_b3, h_b4;
    logic [7:0] p_a, p_b;
    logic       accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    // Header sums start from zero: class, id, length low, length high.
    assign h_a1 = i_msg_class;
    assign h_a2 = h_a1 + i_msg_id;
    assign h_b2 = h_a1 + h_a2;
    assign h_a3 = h_a2 + i_payload_length[7:0];
    assign h_b3 = h_b2 + h_a3;
    assign h_a4 = h_a3 + i_payload_length[15:8];
    assign h_b4 = h_b3 + h_a4;

    assign p_a = r_sum_a + i_payload_byte;
    assign p_b = r_sum_b + p_a;

    always_comb begin
        n_sum_a      = r_sum_a;
        n_sum_b      = r_sum_b;
        n_bytes_left = r_bytes_left;
        n_frame_open = r_frame_open;
        o_cmd.kind      = CMD_ERROR;
        o_cmd.msg_class = i_msg_class;
        o_cmd.msg_id    = i_msg_id;
        o_cmd.len_lo    = i_payload_length[7:0];
        o_cmd.len_hi    = i_payload_length[15:8];
        o_cmd.pbyte     = i_payload_byte;
        o_cmd.sum_a     = h_a4;
        o_cmd.sum_b     = h_b4;
        o_cmd.closes    = 1'b0;
        if (i_req_type == REQ_START) begin
            o_cmd.kind   = CMD_START;
            o_cmd.closes = (i_payload_length == 16'd0);
            n_sum_a      = h_a4;
            n_sum_b      = h_b4;
            n_bytes_left = i_payload_length;
            n_frame_open = (i_payload_length != 16'd0);
        end else if (r_frame_open) begin
            o_cmd.kind   = CMD_PAYLOAD;
            o_cmd.sum_a  = p_a;
            o_cmd.sum_b  = p_b;
            o_cmd.closes = (r_bytes_left == 16'd1);
            n_sum_a      = p_a;
            n_sum_b      = p_b;
            n_bytes_left = r_bytes_left - 16'd1;
            n_frame_open = (r_bytes_left != 16'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_a      <= '0;
            r_sum_b      <= '0;
            r_bytes_left <= '0;
            r_frame_open <= 1'b0;
        end else if (accept) begin
            r_sum_a      <= n_sum_a;
            r_sum_b      <= n_sum_b;
            r_bytes_left <= n_bytes_left;
            r_frame_open <= n_frame_open;
        end
    end

    // An open frame always has payload bytes still to come.
    a_open_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_open |-> (r_bytes_left != 16'd0))
        else $error("open frame with no bytes left");

    // A payload item with no open frame must become an error command.
    a_orphan_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type == REQ_PAYLOAD && !r_frame_open) |-> o_cmd.kind == CMD_ERROR)
        else $error("orphan payload not flagged");

endmodule

// ===== design/cmf_queue.sv =====
// Short command queue between the front and back of the framer.
// Register-based FIFO of t_cmd entries; uses cmf_pkg.
module cmf_queue
    import cmf_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule

// ===== design/cmf_back.sv =====
// Back end of the framer: expands each queued command into output bytes,
// one per cycle while the output is not stalled, through a registered output stage. Uses cmf_pkg.
module cmf_back
    import cmf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last,
    output logic       o_frame_end,
    output logic       o_error
);

    logic [2:0] r_step;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last, r_frame_end, r_error;

    logic [7:0] n_byte;
    logic       n_last, n_frame_end, n_error, step_final;
    logic       load;

    assign load  = (!r_valid || i_ready) && !i_empty;
    assign o_pop = load && step_final;

    always_comb begin
        n_byte      = 8'd0;
        n_last      = 1'b0;
        n_frame_end = 1'b0;
        n_error     = 1'b0;
        step_final  = 1'b1;
        unique case (i_cmd.kind)
            CMD_START: begin
                step_final = i_cmd.closes ? (r_step == STEP_HDR_B) : (r_step == STEP_LEN_HI);
                case (r_step)
                    STEP_SYNC1:  n_byte = SYNC_FIRST;
                    STEP_SYNC2:  n_byte = SYNC_SECOND;
                    STEP_CLASS:  n_byte = i_cmd.msg_class;
                    STEP_ID:     n_byte = i_cmd.msg_id;
                    STEP_LEN_LO: n_byte = i_cmd.len_lo;
                    STEP_LEN_HI: begin
                        n_byte = i_cmd.len_hi;
                        // An empty frame flags its length byte as well.
                        n_last = i_cmd.closes;
                    end
                    STEP_HDR_A:  n_byte = i_cmd.sum_a;
                    default: begin
                        n_byte      = i_cmd.sum_b;
                        n_last      = 1'b1;
                        n_frame_end = 1'b1;
                    end
                endcase
            end
            CMD_PAYLOAD: begin
                step_final = i_cmd.closes ? (r_step == STEP_PB_B) : (r_step == STEP_PB);
                case (r_step)
                    STEP_PB: begin
                        n_byte = i_cmd.pbyte;
                        n_last = !i_cmd.closes;
                    end
                    STEP_PB_A: n_byte = i_cmd.sum_a;
                    default: begin
                        n_byte      = i_cmd.sum_b;
                        n_last      = 1'b1;
                        n_frame_end = 1'b1;
                    end
                endcase
            end
            default: begin
                n_last  = 1'b1;
                n_error = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_step <= step_final ? 3'd0 : r_step + 3'd1;
            end
            if (!r_valid || i_ready) begin
                r_valid <= !i_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte      <= n_byte;
            r_last      <= n_last;
            r_frame_end <= n_frame_end;
            r_error     <= n_error;
        end
    end

    assign o_valid     = r_valid;
    assign o_byte      = r_byte;
    assign o_last      = r_last;
    assign o_frame_end = r_frame_end;
    assign o_error     = r_error;

    a_fend_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_frame_end) |-> r_last)
        else $error("frame end without last");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_error) |-> (r_byte == 8'd0 && r_last && !r_frame_end))
        else $error("malformed error result");

endmodule

// ===== design/checksummed_message_framer_top.sv =====
// The first result of an item passes the queue write and then the output register before it is
// presented, when the queue is empty and the output register is free.
// Throughput: the front takes one item per cycle while the queue has room; the back emits one byte
// per cycle: one for a payload byte or an error, three for the payload byte that closes a frame,
// six for a start item and eight for an empty frame. Output stalls hold the back in place.
// Reset is synchronous and active low: it clears the sums, the frame state, the queue and the
// output valid flag.
module checksummed_message_framer_top
    import cmf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: msg_class[7:0], msg_id[15:8], payload_length[31:16],
    // payload_byte[39:32].
    input  logic [39:0] s_axis_tdata,
    // tuser from bit 0: req_type.
    input  logic [0:0]  s_axis_tuser,
    // Framed byte stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0: out_byte[7:0].
    output logic [7:0]  m_axis_tdata,
    // tlast carries run_last: it marks the final item caused by one request, except after the header
    // of a frame that still expects payload bytes; an empty frame also flags its length byte.
    output logic        m_axis_tlast,
    // tuser from bit 0: frame_end, error.
    output logic [1:0]  m_axis_tuser
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic push, pop, full, empty;

    // The front classifies each request and keeps the running Fletcher sums,
    // so the checksum bytes travel inside the command and the back never
    // needs the frame state.
    cmf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_req_type       (s_axis_tuser[0]),
        .i_msg_class      (s_axis_tdata[7:0]),
        .i_msg_id         (s_axis_tdata[15:8]),
        .i_payload_length (s_axis_tdata[31:16]),
        .i_payload_byte   (s_axis_tdata[39:32]),
        .i_full           (full),
        .o_push           (push),
        .o_cmd            (front_cmd)
    );

    // The queue decouples the front, which issues one command per item, from the multi-byte back.
    cmf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    // The back walks each command step by step into the output register.
    cmf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_cmd       (queue_cmd),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .o_frame_end (m_axis_tuser[0]),
        .o_error     (m_axis_tuser[1])
    );

endmodule

// ===== dv/checksummed_message_framer_top_tb.sv =====
// Self-checking testbench for checksummed_message_framer_top: directed and random request items,
// with a cycle-free predictor of the framed byte stream and 8-bit Fletcher sums (modulo 256).
// Depends on cmf_pkg and the framer RTL only.
module checksummed_message_framer_top_tb;
    import cmf_pkg::*;

    typedef struct packed {
        logic        req;
        logic [7:0]  cls;
        logic [7:0]  id;
        logic [15:0] len;
        logic [7:0]  pb;
    } t_request;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fend;
        logic       err;
    } t_frame_byte;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    checksummed_message_framer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    t_request    pending_requests[$];
    t_frame_byte frame_bytes_due[$];

    // Shadow copy of the framer state.
    logic [7:0]  fl_sum_a;
    logic [7:0]  fl_sum_b;
    logic [15:0] payload_left;
    logic        frame_open;

    int   mismatches = 0;
    logic stim_go = 1'b0;
    logic req_taken = 1'b0;
    int   burst_left = 8;
    int   gap_left = 0;
    int   stall_mode = 0;
    int   stall_cycles = 100;
    int   cyc = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Generous watchdog: far above the slowest legal run.
    initial begin
        #800000;
        $display("checksummed_message_framer_top verification failed");
        $finish;
    end

    function automatic t_request rand_request(input logic req);
        t_request r;
        r.req = req;
        r.cls = 8'($urandom);
        r.id  = 8'($urandom);
        r.len = 16'($urandom);
        r.pb  = 8'($urandom);
        return r;
    endfunction

    task automatic add_start(input logic [7:0] cls, input logic [7:0] id, input logic [15:0] len);
        t_request r;
        r = rand_request(REQ_START);
        r.cls = cls;
        r.id  = id;
        r.len = len;
        pending_requests.push_back(r);
    endtask

    task automatic add_payload(input logic [7:0] pb);
        t_request r;
        r = rand_request(REQ_PAYLOAD);
        r.pb = pb;
        pending_requests.push_back(r);
    endtask

    task automatic push_byte(input logic [7:0] data, input logic last, input logic fend,
                             input logic err);
        t_frame_byte b;
        b.data = data;
        b.last = last;
        b.fend = fend;
        b.err  = err;
        frame_bytes_due.push_back(b);
    endtask

    task automatic add_to_sums(input logic [7:0] b);
        fl_sum_a = fl_sum_a + b;
        fl_sum_b = fl_sum_b + fl_sum_a;
    endtask

    // Works out the bytes that one accepted request item produces.
    task automatic predict_frame_bytes(input t_request r);
        logic empty;
        if (r.req == REQ_START) begin
            empty = (r.len == 16'd0);
            fl_sum_a = 8'd0;
            fl_sum_b = 8'd0;
            add_to_sums(r.cls);
            add_to_sums(r.id);
            add_to_sums(r.len[7:0]);
            add_to_sums(r.len[15:8]);
            push_byte(SYNC_FIRST, 1'b0, 1'b0, 1'b0);
            push_byte(SYNC_SECOND, 1'b0, 1'b0, 1'b0);
            push_byte(r.cls, 1'b0, 1'b0, 1'b0);
            push_byte(r.id, 1'b0, 1'b0, 1'b0);
            push_byte(r.len[7:0], 1'b0, 1'b0, 1'b0);
            push_byte(r.len[15:8], empty, 1'b0, 1'b0);
            if (empty) begin
                push_byte(fl_sum_a, 1'b0, 1'b0, 1'b0);
                push_byte(fl_sum_b, 1'b1, 1'b1, 1'b0);
                frame_open = 1'b0;
                payload_left = 16'd0;
            end else begin
                frame_open = 1'b1;
                payload_left = r.len;
            end
        end else if (!frame_open) begin
            // Stray payload byte: one error item, state untouched.
            push_byte(8'd0, 1'b1, 1'b0, 1'b1);
        end else begin
            add_to_sums(r.pb);
            payload_left = payload_left - 16'd1;
            if (payload_left == 16'd0) begin
                push_byte(r.pb, 1'b0, 1'b0, 1'b0);
                push_byte(fl_sum_a, 1'b0, 1'b0, 1'b0);
                push_byte(fl_sum_b, 1'b1, 1'b1, 1'b0);
                frame_open = 1'b0;
            end else begin
                push_byte(r.pb, 1'b1, 1'b0, 1'b0);
            end
        end
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        if (!stim_go) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !req_taken) begin
            // Hold the current item until it is accepted.
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {pending_requests[0].pb, pending_requests[0].len,
                              pending_requests[0].id, pending_requests[0].cls};
            s_axis_tuser  <= pending_requests[0].req;
            void'(pending_requests.pop_front());
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 24);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver back-pressure: a mode that changes every so often.
    always @(negedge i_clk) begin
        cyc <= cyc + 1;
        if (stall_cycles == 0) begin
            stall_mode   <= $urandom_range(0, 3);
            stall_cycles <= $urandom_range(64, 256);
        end else begin
            stall_cycles <= stall_cycles - 1;
        end
        case (stall_mode)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= 1'($urandom);
            end
            2: begin
                m_axis_tready <= (cyc[1:0] == 2'd0);
            end
            default: begin
                m_axis_tready <= cyc[3];
            end
        endcase
    end

    // Input monitor: every accepted request goes through the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_frame_bytes('{req: s_axis_tuser[0], cls: s_axis_tdata[7:0],
                                  id: s_axis_tdata[15:8], len: s_axis_tdata[31:16],
                                  pb: s_axis_tdata[39:32]});
            req_taken <= 1'b1;
        end else begin
            req_taken <= 1'b0;
        end
    end

    // Output monitor: compare each accepted byte with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (frame_bytes_due.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected byte %h last %b user %b", m_axis_tdata, m_axis_tlast,
                             m_axis_tuser);
            end else begin
                if (m_axis_tdata !== frame_bytes_due[0].data ||
                    m_axis_tlast !== frame_bytes_due[0].last ||
                    m_axis_tuser[0] !== frame_bytes_due[0].fend ||
                    m_axis_tuser[1] !== frame_bytes_due[0].err) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected byte %h last %b end %b err %b, got %h %b %b %b",
                                 frame_bytes_due[0].data, frame_bytes_due[0].last,
                                 frame_bytes_due[0].fend, frame_bytes_due[0].err,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser[0], m_axis_tuser[1]);
                end
                void'(frame_bytes_due.pop_front());
            end
        end
    end

    initial begin
        int n;
        int pick;
        int len;
        int k;
        fl_sum_a = 8'd0;
        fl_sum_b = 8'd0;
        payload_left = 16'd0;
        frame_open = 1'b0;

        // Directed part: stray payloads, empty frames at both extremes, sum wrap,
        // abandoned frames and a frame closing on its single payload byte.
        add_payload(8'hFF);
        add_payload(8'h00);
        add_start(8'hFF, 8'hFF, 16'h0000);
        add_start(8'h00, 8'h00, 16'h0000);
        add_start(8'hA5, 8'h5A, 16'h0001);
        add_payload(8'hFF);
        add_payload(8'h3C);
        add_start(8'h12, 8'h34, 16'hFFFF);
        add_payload(8'h80);
        add_start(8'hFF, 8'h01, 16'h0003);
        add_payload(8'hFF);
        add_payload(8'hFF);
        add_payload(8'hFF);
        add_start(8'h01, 8'h02, 16'h0100);
        add_payload(8'h11);
        add_start(8'h7F, 8'h80, 16'h8000);
        add_start(8'hC3, 8'h3C, 16'h0002);
        add_payload(8'h00);
        add_payload(8'hFF);
        add_payload(8'h55);

        // Random part: mostly complete frames, some abandoned ones, some stray bytes.
        n = 0;
        while (n < 400) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
                add_start(8'($urandom), 8'($urandom), 16'(len));
                for (k = 0; k < len; k++)
                    add_payload(8'($urandom));
                n += len + 1;
            end else if (pick < 87) begin
                len = $urandom_range(0, 3);
                add_start(8'($urandom), 8'($urandom), 16'($urandom));
                for (k = 0; k < len; k++)
                    add_payload(8'($urandom));
                n += len + 1;
            end else begin
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++)
                    add_payload(8'($urandom));
                n += len;
            end
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        stim_go = 1'b1;

        while (pending_requests.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (frame_bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && frame_bytes_due.size() == 0)
            $display("checksummed_message_framer_top verification clean");
        else
            $display("checksummed_message_framer_top verification failed");
        $finish;
    end

endmodule
